FILE: rtl/core/rbol_pkg.sv
`default_nettype none

package rbol_pkg;

   // Field widths of one request and one result.
   localparam int unsigned TAG_W = 32;
   localparam int unsigned LEN_W = 16;
   localparam int unsigned POS_W = 20;

   // Request tdata: new_tag, new_length, char_position from the lowest bit up.
   localparam int unsigned REQ_TAG_LSB   = 0;
   localparam int unsigned REQ_LEN_LSB   = REQ_TAG_LSB + TAG_W;
   localparam int unsigned REQ_POS_LSB   = REQ_LEN_LSB + LEN_W;
   localparam int unsigned REQ_USED_W    = REQ_POS_LSB + POS_W;
   localparam int unsigned REQ_TDATA_W   = ((REQ_USED_W + 7) / 8) * 8;

   // Result tdata: hit, found_tag, byte_in_entry, evicted, evicted_tag.
   localparam int unsigned RSP_USED_W    = 1 + TAG_W + LEN_W + 1 + TAG_W;
   localparam int unsigned RSP_TDATA_W   = ((RSP_USED_W + 7) / 8) * 8;
   localparam int unsigned RSP_PAD_W     = RSP_TDATA_W - RSP_USED_W;

   // One stored entry: length above tag.
   localparam int unsigned ENTRY_W = TAG_W + LEN_W;

   typedef logic [2:0] step_type;

   localparam step_type STEP_IDLE  = 3'd0;
   localparam step_type STEP_ADD0  = 3'd1;
   localparam step_type STEP_ADD1  = 3'd2;
   localparam step_type STEP_FIND0 = 3'd3;
   localparam step_type STEP_FIND1 = 3'd4;
   localparam step_type STEP_EMIT  = 3'd5;

   typedef enum logic [2:0] {
      JMP_NEXT,
      JMP_ALWAYS,
      JMP_WAIT_REQ,
      JMP_IF_EMPTY,
      JMP_WALK,
      JMP_WAIT_RSP
   } jump_type;

   typedef struct packed {
      logic     accept;
      logic     rd_rp;
      logic     rd_walk;
      logic     add_commit;
      logic     find_init;
      logic     find_step;
      logic     emit;
      jump_type jump;
      step_type target;
   } ctrl_word_type;

   typedef struct packed {
      logic req_fire;
      logic find_mode;
      logic ring_empty;
      logic walk_stop;
      logic rsp_free;
   } seq_status_type;

   // The microprogram. Each step drives the datapath and names how to branch.
   function automatic ctrl_word_type program_word(input step_type step);
      ctrl_word_type word;
      word = '0;
      unique case (step)
         STEP_IDLE: begin
            word.accept = 1'b1;
            word.jump   = JMP_WAIT_REQ;
            word.target = STEP_FIND0;
         end
         STEP_ADD0: begin
            word.rd_rp  = 1'b1;
            word.jump   = JMP_NEXT;
         end
         STEP_ADD1: begin
            word.add_commit = 1'b1;
            word.jump       = JMP_ALWAYS;
            word.target     = STEP_EMIT;
         end
         STEP_FIND0: begin
            word.rd_rp     = 1'b1;
            word.find_init = 1'b1;
            word.jump      = JMP_IF_EMPTY;
            word.target    = STEP_EMIT;
         end
         STEP_FIND1: begin
            word.rd_walk   = 1'b1;
            word.find_step = 1'b1;
            word.jump      = JMP_WALK;
            word.target    = STEP_EMIT;
         end
         STEP_EMIT: begin
            word.emit   = 1'b1;
            word.jump   = JMP_WAIT_RSP;
            word.target = STEP_IDLE;
         end
         default: begin
            word.jump   = JMP_ALWAYS;
            word.target = STEP_IDLE;
         end
      endcase
      return word;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ring_buffer_offset_lookup_unit.sv
// Overwriting ring of SLOTS entries, each an opaque 32-bit tag with a 16-bit
// byte length, with lookup by character offset. A request with tuser low adds
// an entry; when the ring is already full the oldest entry is dropped first and
// its tag comes back as evicted_tag. A request with tuser high finds the entry
// that holds char_position within the concatenation of all stored entries,
// oldest first, and returns its tag and the byte position inside it, or a miss
// when the offset lies at or beyond the end of the stored data. Zero-length
// entries never match. Every request gives exactly one response. An add reads
// the oldest entry, writes the new one and then loads its response into the
// output register. A find reads the oldest entry and walks the stored entries,
// oldest first, until the covering entry is reached or the stored data runs
// out, then loads its response into the output register. The walk covers at
// most SLOTS entries, and none on an empty ring; it reads the single read port
// of the entry memory once per cycle. The block works on one request at a
// time, driven by a small microprogram. A response waiting in the output
// register does not block acceptance of the next request, but the response of
// that next request waits in its final step until the register is free. Reset
// empties the ring at once; no clearing pass is needed.

`default_nettype none

module ring_buffer_offset_lookup_unit #(
   parameter int unsigned SLOTS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   // Fields from bit 0 up: new_tag[31:0], new_length[47:32],
   // char_position[67:48], zero fill [71:68].
   input  wire logic [rbol_pkg::REQ_TDATA_W-1:0] req_tdata,
   // Fields: mode (0 = add entry, 1 = find entry).
   input  wire logic                             req_tuser,
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   // Fields from bit 0 up: hit[0], found_tag[32:1], byte_in_entry[48:33],
   // evicted[49], evicted_tag[81:50], zero fill [87:82].
   output      logic [rbol_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   rbol_pkg::ctrl_word_type  cw;
   rbol_pkg::seq_status_type status;
   logic                     req_fire;

   // The microprogram opens the request port only in its idle step.
   assign req_tready = cw.accept;
   assign req_fire   = req_tvalid && cw.accept;

   rbol_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cw     (cw)
   );

   rbol_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cw         (cw),
      .status     (status),
      .req_fire   (req_fire),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

FILE: rtl/core/rbol_ram.sv
`default_nettype none

module rbol_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/rbol_seq.sv
`default_nettype none

module rbol_seq (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire rbol_pkg::seq_status_type status,
   output      rbol_pkg::ctrl_word_type  cw
);

   rbol_pkg::step_type step_ff;
   rbol_pkg::step_type step_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= rbol_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      cw      = rbol_pkg::program_word(step_ff);
      step_in = step_ff;
      unique case (cw.jump)
         rbol_pkg::JMP_NEXT: begin
            step_in = step_ff + 3'd1;
         end
         rbol_pkg::JMP_ALWAYS: begin
            step_in = cw.target;
         end
         rbol_pkg::JMP_WAIT_REQ: begin
            // An add falls through to the next step, a find branches.
            if (status.req_fire) begin
               step_in = status.find_mode ? cw.target : step_ff + 3'd1;
            end
         end
         rbol_pkg::JMP_IF_EMPTY: begin
            step_in = status.ring_empty ? cw.target : step_ff + 3'd1;
         end
         rbol_pkg::JMP_WALK: begin
            if (status.walk_stop) begin
               step_in = cw.target;
            end
         end
         rbol_pkg::JMP_WAIT_RSP: begin
            if (status.rsp_free) begin
               step_in = cw.target;
            end
         end
         default: begin
            step_in = rbol_pkg::STEP_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/core/rbol_dp.sv
`default_nettype none

module rbol_dp #(
   parameter int unsigned SLOTS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire rbol_pkg::ctrl_word_type            cw,
   output      rbol_pkg::seq_status_type           status,
   input  wire logic                               req_fire,
   input  wire logic [rbol_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  wire logic                               req_tuser,
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   output      logic [rbol_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int unsigned PW   = $clog2(SLOTS);
   localparam int unsigned CW   = $clog2(SLOTS + 1);
   localparam int unsigned EW   = rbol_pkg::LEN_W + CW;
   localparam int unsigned CMPW = (EW > rbol_pkg::POS_W) ? EW : rbol_pkg::POS_W;

   function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
      return (p == PW'(SLOTS - 1)) ? '0 : p + PW'(1);
   endfunction

   // Captured request fields.
   logic [rbol_pkg::TAG_W-1:0] new_tag_ff;
   logic [rbol_pkg::LEN_W-1:0] new_len_ff;
   logic [rbol_pkg::POS_W-1:0] pos_ff;

   // Ring state.
   logic [PW-1:0] wp_ff, wp_in;
   logic [PW-1:0] rp_ff, rp_in;
   logic          full_ff, full_in;

   // Walk state.
   logic [PW-1:0] wk_ff, wk_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [EW-1:0] end_ff, end_in;

   // Working result.
   logic                       hit_ff, hit_in;
   logic [rbol_pkg::TAG_W-1:0] found_ff, found_in;
   logic [rbol_pkg::LEN_W-1:0] byte_ff, byte_in;
   logic                       ev_ff, ev_in;
   logic [rbol_pkg::TAG_W-1:0] evtag_ff, evtag_in;

   // Output register.
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [rbol_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [rbol_pkg::ENTRY_W-1:0] rd_data;
   logic [rbol_pkg::TAG_W-1:0]   rd_tag;
   logic [rbol_pkg::LEN_W-1:0]   rd_len;
   logic [PW-1:0]                rd_addr;
   logic [CW-1:0]                count_now;
   logic [EW-1:0]                sum;
   logic [CMPW-1:0]              sum_ext, end_ext, pos_ext, diff;
   logic                         hit_now;
   logic                         rsp_free;

   assign rd_tag  = rd_data[rbol_pkg::TAG_W-1:0];
   assign rd_len  = rd_data[rbol_pkg::ENTRY_W-1:rbol_pkg::TAG_W];
   assign rd_addr = cw.rd_walk ? wk_ff : rp_ff;

   rbol_ram #(
      .WIDTH (rbol_pkg::ENTRY_W),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cw.add_commit),
      .wr_addr (wp_ff),
      .wr_data ({new_len_ff, new_tag_ff}),
      .rd_en   (cw.rd_rp | cw.rd_walk),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      if (full_ff) begin
         count_now = CW'(SLOTS);
      end else if (wp_ff >= rp_ff) begin
         count_now = CW'(wp_ff) - CW'(rp_ff);
      end else begin
         count_now = CW'(SLOTS) - CW'(rp_ff) + CW'(wp_ff);
      end
   end

   assign sum     = end_ff + EW'(rd_len);
   assign sum_ext = CMPW'(sum);
   assign end_ext = CMPW'(end_ff);
   assign pos_ext = CMPW'(pos_ff);
   assign diff    = pos_ext - end_ext;
   assign hit_now = sum_ext > pos_ext;

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      status.req_fire   = req_fire;
      status.find_mode  = req_tuser;
      status.ring_empty = (count_now == '0);
      status.walk_stop  = hit_now || (cnt_ff == CW'(1));
      status.rsp_free   = rsp_free;
   end

   always_comb begin
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      full_in      = full_ff;
      wk_in        = wk_ff;
      cnt_in       = cnt_ff;
      end_in       = end_ff;
      hit_in       = hit_ff;
      found_in     = found_ff;
      byte_in      = byte_ff;
      ev_in        = ev_ff;
      evtag_in     = evtag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (cw.add_commit) begin
         // The oldest entry was read out in the step before.
         hit_in   = 1'b0;
         found_in = '0;
         byte_in  = '0;
         ev_in    = full_ff;
         evtag_in = full_ff ? rd_tag : '0;
         rp_in    = full_ff ? next_slot(rp_ff) : rp_ff;
         wp_in    = next_slot(wp_ff);
         full_in  = (wp_in == rp_in);
      end

      if (cw.find_init) begin
         hit_in   = 1'b0;
         found_in = '0;
         byte_in  = '0;
         ev_in    = 1'b0;
         evtag_in = '0;
         end_in   = '0;
         cnt_in   = count_now;
         wk_in    = next_slot(rp_ff);
      end

      if (cw.find_step) begin
         end_in = sum;
         cnt_in = cnt_ff - CW'(1);
         wk_in  = next_slot(wk_ff);
         if (hit_now) begin
            hit_in   = 1'b1;
            found_in = rd_tag;
            byte_in  = diff[rbol_pkg::LEN_W-1:0];
         end
      end

      if (cw.emit && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{rbol_pkg::RSP_PAD_W{1'b0}}, evtag_ff, ev_ff, byte_ff, found_ff, hit_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= '0;
         rp_ff        <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         new_tag_ff <= req_tdata[rbol_pkg::REQ_TAG_LSB +: rbol_pkg::TAG_W];
         new_len_ff <= req_tdata[rbol_pkg::REQ_LEN_LSB +: rbol_pkg::LEN_W];
         pos_ff     <= req_tdata[rbol_pkg::REQ_POS_LSB +: rbol_pkg::POS_W];
      end
      wk_ff       <= wk_in;
      cnt_ff      <= cnt_in;
      end_ff      <= end_in;
      hit_ff      <= hit_in;
      found_ff    <= found_in;
      byte_ff     <= byte_in;
      ev_ff       <= ev_in;
      evtag_ff    <= evtag_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: sim/tb_ring_buffer_offset_lookup_unit.sv
`default_nettype none

module tb_ring_buffer_offset_lookup_unit;

   import rbol_pkg::*;

   // The ring depth that the block is built with here.
   localparam int unsigned SLOTS = 16;

   // The kind of request is carried on req_tuser.
   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_FIND = 1'b1;

   localparam int unsigned RANDOM_REQUESTS = 1150;
   localparam int unsigned QUIET_TAIL      = 150;
   localparam int unsigned LONG_HOLD       = 150;
   localparam int unsigned DRAIN_CYCLES    = 40;
   localparam int unsigned RUN_LIMIT       = 400000;
   localparam int unsigned MAX_REPORTS     = 10;
   localparam logic [POS_W-1:0] POS_MAX    = '1;

   // One response, with the lowest field last so that it lines up with rsp_tdata.
   typedef struct packed {
      logic [TAG_W-1:0] evicted_tag;
      logic             evicted;
      logic [LEN_W-1:0] byte_in_entry;
      logic [TAG_W-1:0] found_tag;
      logic             hit;
   } lookup_result_type;

   // Keeps a private copy of the ring, works out the response to every accepted
   // request, and compares the responses of the block against those, in order.
   class ring_lookup_checker;
      logic [TAG_W-1:0]  tags    [SLOTS];
      logic [LEN_W-1:0]  lengths [SLOTS];
      int unsigned       wr_ptr;
      int unsigned       rd_ptr;
      bit                full;
      lookup_result_type awaited[$];
      int unsigned       mismatches;

      function new();
         wr_ptr     = 0;
         rd_ptr     = 0;
         full       = 1'b0;
         mismatches = 0;
         foreach (tags[i]) begin
            tags[i]    = '0;
            lengths[i] = '0;
         end
      endfunction

      function int unsigned held_entries();
         return full ? SLOTS : (wr_ptr + SLOTS - rd_ptr) % SLOTS;
      endfunction

      // Byte offset at which the k-th oldest entry starts.
      function int unsigned entry_offset(int unsigned k);
         int unsigned sum;
         sum = 0;
         for (int unsigned i = 0; i < k; i++) begin
            sum += lengths[(rd_ptr + i) % SLOTS];
         end
         return sum;
      endfunction

      function void note_request(logic is_find, logic [REQ_TDATA_W-1:0] data);
         lookup_result_type res;
         int unsigned       count;
         int unsigned       p;
         int unsigned       span_end;
         int unsigned       offset_in;
         logic [POS_W-1:0]  pos;
         res = '0;
         if (is_find == MODE_ADD) begin
            // A full ring drops its oldest entry before the new one goes in.
            if (full) begin
               res.evicted     = 1'b1;
               res.evicted_tag = tags[rd_ptr];
               rd_ptr          = (rd_ptr + 1) % SLOTS;
            end
            tags[wr_ptr]    = data[REQ_TAG_LSB +: TAG_W];
            lengths[wr_ptr] = data[REQ_LEN_LSB +: LEN_W];
            wr_ptr          = (wr_ptr + 1) % SLOTS;
            full            = (wr_ptr == rd_ptr);
         end else begin
            // Walk oldest to newest; zero-length entries can never cover the offset.
            pos      = data[REQ_POS_LSB +: POS_W];
            count    = held_entries();
            p        = rd_ptr;
            span_end = 0;
            for (int unsigned i = 0; i < count && !res.hit; i++) begin
               span_end += lengths[p];
               if (span_end > pos) begin
                  offset_in         = pos - (span_end - lengths[p]);
                  res.hit           = 1'b1;
                  res.found_tag     = tags[p];
                  res.byte_in_entry = offset_in[LEN_W-1:0];
               end
               p = (p + 1) % SLOTS;
            end
         end
         awaited.push_back(res);
      endfunction

      function void check_response(logic [RSP_TDATA_W-1:0] data);
         lookup_result_type got;
         lookup_result_type want;
         got = data[RSP_USED_W-1:0];
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("response with no request outstanding: %h", data);
            return;
         end
         want = awaited.pop_front();
         if (got.hit !== want.hit || got.found_tag !== want.found_tag ||
             got.byte_in_entry !== want.byte_in_entry || got.evicted !== want.evicted ||
             got.evicted_tag !== want.evicted_tag) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("mismatch: expected hit=%0b tag=%h byte=%0d ev=%0b ev_tag=%h",
                        want.hit, want.found_tag, want.byte_in_entry, want.evicted,
                        want.evicted_tag);
               $display("          got      hit=%0b tag=%h byte=%0d ev=%0b ev_tag=%h",
                        got.hit, got.found_tag, got.byte_in_entry, got.evicted,
                        got.evicted_tag);
            end
         end
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = MODE_ADD;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   ring_lookup_checker ring_check = new();

   // Percentage chance of an idle burst before a request or a response; both
   // sides share it so that quiet and busy stretches line up.
   int unsigned idle_pct      = 0;
   bit          hold_responses = 1'b0;
   int unsigned cycle_count    = 0;

   ring_buffer_offset_lookup_unit #(
      .SLOTS(SLOTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The run is cut off if the block stops making progress.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Both handshakes are observed at the rising edge, before any register of the
   // block has taken its new value. A response always belongs to an older
   // request, so checking it before noting a request at the same edge is safe.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            ring_check.check_response(rsp_tdata);
         if (req_tvalid && req_tready)
            ring_check.note_request(req_tuser, req_tdata);
      end
   end

   // The receiver stalls in short random bursts. When asked, it holds off for a
   // long stretch so that the block backs up and stops taking requests.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_responses) begin
            hold_responses = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [REQ_TDATA_W-1:0] pack_request(logic [TAG_W-1:0] tag,
                                                           logic [LEN_W-1:0] len,
                                                           logic [POS_W-1:0] pos);
      logic [REQ_TDATA_W-1:0] data;
      data = '0;
      data[REQ_TAG_LSB +: TAG_W] = tag;
      data[REQ_LEN_LSB +: LEN_W] = len;
      data[REQ_POS_LSB +: POS_W] = pos;
      return data;
   endfunction

   // Called at a falling edge; returns at the falling edge after the request was
   // taken, so that a following request keeps tvalid high without a gap.
   task automatic offer_request(logic is_find, logic [REQ_TDATA_W-1:0] data);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= is_find;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // The fields that the other kind of request uses are filled with noise; the
   // block has to ignore them.
   task automatic send_add(logic [TAG_W-1:0] tag, logic [LEN_W-1:0] len);
      offer_request(MODE_ADD, pack_request(tag, len, POS_W'($urandom)));
   endtask

   task automatic send_find(logic [POS_W-1:0] pos);
      offer_request(MODE_FIND, pack_request($urandom, LEN_W'($urandom), pos));
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (ring_check.awaited.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Mostly short entries so that random offsets land across many of them, with
   // zero-length and full-size entries mixed in.
   function automatic logic [LEN_W-1:0] pick_length();
      int unsigned sel;
      sel = $urandom_range(0, 15);
      if (sel < 2)
         return '0;
      else if (sel == 2)
         return '1;
      else if (sel == 3)
         return LEN_W'($urandom);
      else if (sel < 6)
         return LEN_W'($urandom_range(1, 4096));
      else
         return LEN_W'($urandom_range(1, 64));
   endfunction

   initial begin
      int unsigned      total;
      int unsigned      sel;
      int unsigned      k;
      int unsigned      lo;
      int unsigned      hi;
      logic [POS_W-1:0] pos;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A find on the empty ring has to miss, whatever the offset.
      send_find('0);
      send_find(POS_MAX);
      // A zero-length entry first, then the largest entry, then a one-byte entry.
      send_add('0, '0);
      send_add('1, '1);
      send_add(32'hA5A5_5A5A, 16'd1);
      // The zero-length entry is passed over, so offset zero lands in the big one.
      send_find('0);
      send_find(POS_W'(16'hFFFE));
      send_find(POS_W'(20'h0FFFF));
      // Exactly at the end of the stored data, and far past it: both miss.
      send_find(POS_W'(20'h10000));
      send_find(POS_MAX);
      // Fill the ring with full-size entries, then overwrite the two oldest ones.
      for (int i = 0; i < 13; i++) send_add($urandom, '1);
      send_add(32'h0000_0001, '1);
      send_add(32'h8000_0000, 16'h8000);
      send_find(POS_MAX);
      send_find(POS_W'(ring_check.entry_offset(SLOTS) - 1));

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         // Each block of requests gets its own amount of idling; the last
         // stretch runs with none at all.
         if (i % 100 == 0) begin
            sel      = $urandom_range(0, 2);
            idle_pct = (i >= RANDOM_REQUESTS - QUIET_TAIL) ? 0 : sel * 25;
         end
         if (i == 300)
            hold_responses = 1'b1;
         if (i == 650)
            wait_for_drain();

         if ($urandom_range(0, 1) == 0) begin
            send_add($urandom, pick_length());
         end else begin
            total = ring_check.entry_offset(ring_check.held_entries());
            sel   = $urandom_range(0, 9);
            if (total == 0 || sel < 2) begin
               pos = POS_W'($urandom);
            end else if (sel == 2) begin
               pos = POS_W'(total);
            end else if (sel == 3) begin
               pos = (total + 16 > POS_MAX) ? POS_MAX : POS_W'(total + $urandom_range(1, 16));
            end else if (sel < 6) begin
               // Aim at the first or last byte of one stored entry.
               k   = $urandom_range(0, ring_check.held_entries() - 1);
               lo  = ring_check.entry_offset(k);
               hi  = ring_check.entry_offset(k + 1);
               pos = ($urandom_range(0, 1) == 0 || hi == 0) ? POS_W'(lo) : POS_W'(hi - 1);
            end else begin
               pos = POS_W'($urandom_range(0, total - 1));
            end
            send_find(pos);
         end
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ring_check.mismatches == 0 && ring_check.awaited.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
rtl/core/rbol_pkg.sv
rtl/core/rbol_ram.sv
rtl/core/rbol_seq.sv
rtl/core/rbol_dp.sv
rtl/core/ring_buffer_offset_lookup_unit.sv
sim/tb_ring_buffer_offset_lookup_unit.sv
